// ===== design/tte_pkg.sv =====
// Package for the tap tempo estimator: widths, reset values, register
// indexes, controller states and the command/status structs.
// Used by tte_ctrl, tte_datapath and tap_tempo_estimator.
package tte_pkg;

   localparam int DEF_HISTORY_DEPTH = 8;

   localparam int TAP_W       = 32;
   localparam int GAP_W       = 24;
   localparam int TEMPO_W     = 16;
   localparam int TAPS_HELD_W = 4;
   localparam int NUMER_W     = 40;
   localparam int DIV_CNT_W   = $clog2(NUMER_W + 1);
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 2;

   localparam logic [NUMER_W-1:0] TEMPO_NUMERATOR = 40'd15360000000;

   localparam logic [GAP_W-1:0]   GAP_LIMIT_RESET     = 24'd3000000;
   localparam logic [TEMPO_W-1:0] TEMPO_FLOOR_RESET   = 16'd15360;
   localparam logic [TEMPO_W-1:0] TEMPO_CEILING_RESET = 16'd51200;
   localparam logic [TEMPO_W-1:0] HELD_TEMPO_RESET    = 16'd30720;

   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_FLOOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_CEILING = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ_OLD,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [GAP_W-1:0]   gap_limit_us;
      logic [TEMPO_W-1:0] tempo_floor_q8;
      logic [TEMPO_W-1:0] tempo_ceiling_q8;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic write_tap;
      logic read_old;
      logic setup;
      logic div_step;
      logic finish;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic multi;
      logic div_done;
   } status_type;

endpackage

// ===== design/tte_ctrl.sv =====
// Controller for the tap tempo estimator: sequences one tap through
// history update, span read, division and result transfer.
// Depends on tte_pkg.
module tte_ctrl
   import tte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_tap = 1'b1;
            state_in      = ST_READ_OLD;
         end
         ST_READ_OLD: begin
            cmd.read_old = 1'b1;
            state_in     = status.multi ? ST_SETUP : ST_RESULT;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != ST_IDLE);

endmodule

// ===== design/tte_datapath.sv =====
// Datapath for the tap tempo estimator: tap ring memory, head and count,
// restoring divider, clamp and result registers.
// Depends on tte_pkg; driven by tte_ctrl commands.
module tte_datapath
   import tte_pkg::*;
#(
   parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  cfg_type                cfg,
   input  logic [TAP_W-1:0]       req_tap_time_us,
   output logic                   rsp_tempo_updated,
   output logic [TEMPO_W-1:0]     rsp_tempo_q8,
   output logic [TAPS_HELD_W-1:0] rsp_taps_held
);

   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W = PTR_W + 2;

   logic [TAP_W-1:0] ring [HISTORY_DEPTH];

   logic [PTR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TEMPO_W-1:0]   held_tempo_ff, held_tempo_in;
   logic [TAP_W-1:0]     now_ff;
   logic [TAP_W-1:0]     rd_data_ff;
   logic [TAP_W-1:0]     span_ff;
   logic                 span_zero_ff;
   logic [NUMER_W-1:0]   quo_ff, quo_in;
   logic [TAP_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [PTR_W-1:0]   head_m1, head_p1, old_idx, rd_addr;
   logic [IDX_W-1:0]   old_sum;
   logic [TAP_W-1:0]   gap, span;
   logic               restart;
   logic [CNT_W-1:0]   count_m1;
   logic [NUMER_W-1:0] numer;
   logic [TAP_W:0]     trial;
   logic [TAP_W:0]     shifted;
   logic [NUMER_W-1:0] floored;
   logic [TEMPO_W-1:0] clamped;
   logic [CNT_W+3:0]   count_wide;

   // ring pointer arithmetic modulo the depth
   assign head_m1 = (head_ff == '0) ? PTR_W'(HISTORY_DEPTH - 1) : head_ff - 1'b1;
   assign head_p1 = (head_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign old_sum = IDX_W'(head_ff) + IDX_W'(HISTORY_DEPTH) - IDX_W'(count_ff);
   assign old_idx = (old_sum >= IDX_W'(HISTORY_DEPTH))
                    ? PTR_W'(old_sum - IDX_W'(HISTORY_DEPTH)) : PTR_W'(old_sum);
   assign rd_addr = cmd.accept ? head_m1 : old_idx;

   always_ff @(posedge clock) begin
      if (cmd.write_tap) begin
         ring[head_ff] <= now_ff;
      end
      if (cmd.accept || cmd.read_old) begin
         rd_data_ff <= ring[rd_addr];
      end
   end

   // history update
   assign gap     = now_ff - rd_data_ff;
   assign restart = (count_ff != '0) && (gap > TAP_W'(cfg.gap_limit_us));

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.write_tap) begin
         head_in = head_p1;
         if (restart) begin
            count_in = CNT_W'(1);
         end else if (count_ff < CNT_W'(HISTORY_DEPTH)) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // divider: numerator * (n-1) over span, one quotient bit per step
   assign span     = now_ff - rd_data_ff;
   assign count_m1 = count_ff - 1'b1;
   assign numer    = TEMPO_NUMERATOR * NUMER_W'(count_m1);
   assign shifted  = {rem_ff, quo_ff[NUMER_W-1]};
   assign trial    = shifted - {1'b0, span_ff};

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.setup) begin
         quo_in     = numer;
         rem_in     = '0;
         div_cnt_in = DIV_CNT_W'(NUMER_W);
      end else if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff - 1'b1;
         if (trial[TAP_W]) begin
            rem_in = shifted[TAP_W-1:0];
            quo_in = {quo_ff[NUMER_W-2:0], 1'b0};
         end else begin
            rem_in = trial[TAP_W-1:0];
            quo_in = {quo_ff[NUMER_W-2:0], 1'b1};
         end
      end
   end

   // floor first, ceiling last
   assign floored = (quo_ff < NUMER_W'(cfg.tempo_floor_q8))
                    ? NUMER_W'(cfg.tempo_floor_q8) : quo_ff;
   assign clamped = (floored > NUMER_W'(cfg.tempo_ceiling_q8))
                    ? cfg.tempo_ceiling_q8 : floored[TEMPO_W-1:0];

   assign held_tempo_in = !cmd.finish ? held_tempo_ff
                        : (span_zero_ff ? cfg.tempo_ceiling_q8 : clamped);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         held_tempo_ff <= HELD_TEMPO_RESET;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         held_tempo_ff <= held_tempo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         now_ff <= req_tap_time_us;
      end
      if (cmd.setup) begin
         span_ff      <= span;
         span_zero_ff <= (span == '0);
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
   end

   // result register
   assign count_wide = {4'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_tempo_updated <= (count_ff >= CNT_W'(2));
         rsp_tempo_q8      <= held_tempo_ff;
         rsp_taps_held     <= (count_wide > (CNT_W+4)'(15))
                              ? TAPS_HELD_W'(15) : count_wide[TAPS_HELD_W-1:0];
      end
   end

   assign status.multi    = (count_ff >= CNT_W'(2));
   assign status.div_done = (div_cnt_ff == '0);

endmodule

// ===== design/tap_tempo_estimator.sv =====
// Top level of the tap tempo estimator: register file, controller and
// datapath. Depends on tte_pkg, tte_ctrl and tte_datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_tap_time_us
//   rsp      out        rsp_valid/rsp_stall  rsp_tempo_updated, rsp_tempo_q8, rsp_taps_held
//   csr      in/out     csr_psel/csr_penable csr_paddr, csr_pwdata, csr_prdata
//
// One tap at a time: the result is loaded after ST_WRITE and ST_READ_OLD when
// the history holds a single tap, and otherwise after ST_SETUP, the 40-step
// restoring divider (one quotient bit per cycle) and ST_FINISH as well; the next
// tap is taken in the cycle after the load. The result register frees the
// controller only once the previous result is transferred; req_stall is high
// from acceptance until the result is loaded. Reset is synchronous and leaves
// the history empty.
module tap_tempo_estimator
   import tte_pkg::*;
#(
   parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TAP_W-1:0]       req_tap_time_us,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_tempo_updated,
   output logic [TEMPO_W-1:0]     rsp_tempo_q8,
   output logic [TAPS_HELD_W-1:0] rsp_taps_held,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;
   logic       csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx)
            CSR_GAP_LIMIT:     cfg_in.gap_limit_us     = csr_pwdata[GAP_W-1:0];
            CSR_TEMPO_FLOOR:   cfg_in.tempo_floor_q8   = csr_pwdata[TEMPO_W-1:0];
            CSR_TEMPO_CEILING: cfg_in.tempo_ceiling_q8 = csr_pwdata[TEMPO_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_GAP_LIMIT:     csr_prdata = CSR_DATA_W'(cfg_ff.gap_limit_us);
         CSR_TEMPO_FLOOR:   csr_prdata = CSR_DATA_W'(cfg_ff.tempo_floor_q8);
         CSR_TEMPO_CEILING: csr_prdata = CSR_DATA_W'(cfg_ff.tempo_ceiling_q8);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_limit_us     <= GAP_LIMIT_RESET;
         cfg_ff.tempo_floor_q8   <= TEMPO_FLOOR_RESET;
         cfg_ff.tempo_ceiling_q8 <= TEMPO_CEILING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tte_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg               (cfg_ff),
      .req_tap_time_us   (req_tap_time_us),
      .rsp_tempo_updated (rsp_tempo_updated),
      .rsp_tempo_q8      (rsp_tempo_q8),
      .rsp_taps_held     (rsp_taps_held)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transfer taken while a tap is in progress");

   a_taps_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_taps_held != '0))
      else $error("result shows an empty history");

   a_update_needs_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tempo_updated) |-> (rsp_taps_held >= TAPS_HELD_W'(2)))
      else $error("tempo update with fewer than two taps held");

endmodule
